@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL; they compile to nothing under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Antecedent in one cycle implies the consequent in the next.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, cond, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/ils_pkg.sv @@
// Types and constants for the integer literal scanner.
package ils_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int OUT_VALUE_W     = 32;
  localparam int OUT_COUNT_W     = 16;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_POINT = 8'h2e;

  // Offset from the low nibble of a letter digit to its value (A is 0x41, value 10).
  localparam logic [3:0] HEX_LETTER_OFS = 4'd9;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ZERO,
    PH_MINUS,
    PH_MINUS_ZERO,
    PH_HEX_START,
    PH_HEX,
    PH_DEC,
    PH_START
  } phase_t;

  typedef enum logic [1:0] {
    ST_INT,
    ST_NAN,
    ST_FLOAT
  } status_t;

  // Control part of the scan state.
  typedef struct packed {
    phase_t phase;
    logic   neg;
  } ils_ctl_t;

  // Result control of one step.
  typedef struct packed {
    logic    emit;
    status_t status;
  } ils_res_t;

endpackage

@@ rtl/ils_step.sv @@
// One scan step: next scan state and optional result for one character.
module ils_step #(
  parameter int VALUE_WIDTH = ils_pkg::VALUE_WIDTH_DEF,
  parameter int COUNT_WIDTH = ils_pkg::COUNT_WIDTH_DEF
) (
  input  logic [7:0]                    ch,
  input  logic                          first,
  input  logic                          last,
  input  ils_pkg::ils_ctl_t             cur_ctl,
  input  logic [VALUE_WIDTH-1:0]        cur_acc,
  input  logic [COUNT_WIDTH-1:0]        cur_cnt,
  output ils_pkg::ils_ctl_t             nxt_ctl,
  output logic [VALUE_WIDTH-1:0]        nxt_acc,
  output logic [COUNT_WIDTH-1:0]        nxt_cnt,
  output ils_pkg::ils_res_t             res,
  output logic [ils_pkg::OUT_VALUE_W-1:0] res_value,
  output logic [ils_pkg::OUT_COUNT_W-1:0] res_consumed
);
  import ils_pkg::*;

  phase_t                  ph;
  logic                    neg0;
  logic [VALUE_WIDTH-1:0]  acc0;
  logic [COUNT_WIDTH-1:0]  cnt0;
  logic                    is_dec;
  logic                    is_hex;
  logic [3:0]              hex_d;
  logic [VALUE_WIDTH-1:0]  acc_dec;
  logic [VALUE_WIDTH-1:0]  acc_hex;
  logic [COUNT_WIDTH-1:0]  cnt_inc;
  logic signed [VALUE_WIDTH-1:0] signed_val;

  // A first character restarts the scan from a clean state.
  assign ph   = first ? PH_START : cur_ctl.phase;
  assign neg0 = first ? 1'b0 : cur_ctl.neg;
  assign acc0 = first ? '0 : cur_acc;
  assign cnt0 = first ? '0 : cur_cnt;

  assign is_dec = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_hex = is_dec || ((ch >= CH_UP_A) && (ch <= CH_UP_F)) ||
                  ((ch >= CH_LO_A) && (ch <= CH_LO_F));
  assign hex_d  = is_dec ? ch[3:0] : (ch[3:0] + HEX_LETTER_OFS);

  // Times ten as two shifts and an add; decimal digits share the low nibble.
  assign acc_dec = {acc0[VALUE_WIDTH-4:0], 3'b000} + {acc0[VALUE_WIDTH-2:0], 1'b0}
                 + {{(VALUE_WIDTH-4){1'b0}}, ch[3:0]};
  assign acc_hex = {acc0[VALUE_WIDTH-5:0], hex_d};
  assign cnt_inc = (&cnt0) ? cnt0 : (cnt0 + COUNT_WIDTH'(1));

  always_comb begin
    nxt_ctl.phase = ph;
    nxt_ctl.neg   = neg0;
    nxt_acc       = acc0;
    nxt_cnt       = cnt0;
    res.emit      = 1'b0;
    res.status    = ST_INT;

    unique case (ph)
      PH_START: begin
        if (ch == CH_ZERO) begin
          nxt_cnt       = cnt_inc;
          nxt_ctl.phase = PH_ZERO;
          res.emit      = last;
        end else if (ch == CH_MINUS) begin
          nxt_ctl.neg   = 1'b1;
          nxt_cnt       = cnt_inc;
          nxt_ctl.phase = PH_MINUS;
          res.emit      = last;
          res.status    = ST_NAN;
        end else if (ch == CH_POINT) begin
          res.emit   = 1'b1;
          res.status = ST_FLOAT;
        end else if (!is_dec) begin
          res.emit   = 1'b1;
          res.status = ST_NAN;
        end else begin
          nxt_acc       = acc_dec;
          nxt_cnt       = cnt_inc;
          nxt_ctl.phase = PH_DEC;
          res.emit      = last;
        end
      end
      PH_MINUS: begin
        if (ch == CH_POINT) begin
          res.emit   = 1'b1;
          res.status = ST_FLOAT;
        end else if (!is_dec) begin
          res.emit   = 1'b1;
          res.status = ST_NAN;
        end else begin
          nxt_acc       = acc_dec;
          nxt_cnt       = cnt_inc;
          nxt_ctl.phase = (ch == CH_ZERO) ? PH_MINUS_ZERO : PH_DEC;
          res.emit      = last;
        end
      end
      PH_ZERO, PH_MINUS_ZERO: begin
        if (ch == CH_LO_X) begin
          nxt_cnt       = cnt_inc;
          nxt_ctl.phase = PH_HEX_START;
          res.emit      = last;
          res.status    = ST_NAN;
        end else if (ch == CH_POINT) begin
          res.emit   = 1'b1;
          res.status = ST_FLOAT;
        end else if (!is_dec) begin
          res.emit = 1'b1;
        end else begin
          nxt_acc       = acc_dec;
          nxt_cnt       = cnt_inc;
          nxt_ctl.phase = PH_DEC;
          res.emit      = last;
        end
      end
      PH_HEX_START, PH_HEX: begin
        if ((ph == PH_HEX) && (ch == CH_POINT)) begin
          res.emit   = 1'b1;
          res.status = ST_FLOAT;
        end else if (!is_hex) begin
          res.emit   = 1'b1;
          res.status = (ph == PH_HEX) ? ST_INT : ST_NAN;
        end else begin
          nxt_acc       = acc_hex;
          nxt_cnt       = cnt_inc;
          nxt_ctl.phase = PH_HEX;
          res.emit      = last;
        end
      end
      PH_DEC: begin
        if (ch == CH_POINT) begin
          res.emit   = 1'b1;
          res.status = ST_FLOAT;
        end else if (!is_dec) begin
          res.emit = 1'b1;
        end else begin
          nxt_acc  = acc_dec;
          nxt_cnt  = cnt_inc;
          res.emit = last;
        end
      end
      PH_IDLE: begin
        nxt_ctl.phase = PH_IDLE;
      end
    endcase

    if (res.emit) begin
      nxt_ctl.phase = PH_IDLE;
    end
  end

  // Only an integer result carries a value and a count.
  assign signed_val   = nxt_ctl.neg ? (-nxt_acc) : nxt_acc;
  assign res_value    = (res.status == ST_INT) ? OUT_VALUE_W'(signed_val) : '0;
  assign res_consumed = (res.status == ST_INT) ? OUT_COUNT_W'(nxt_cnt) : '0;

endmodule

@@ rtl/integer_literal_scanner_core.sv @@
// Top level of the integer literal scanner: input register, scan step, result register.
//
// The scanner reads one text byte per beat and parses one integer literal: an optional
// minus sign, then decimal digits or a 0x prefix with hex digits in either case. A byte
// with in_first_char set starts a scan, dropping any scan in progress. The result beat
// comes on the first byte that is not part of the literal, or on the byte flagged
// in_last_char, and carries a status (integer, not a number, or floating-point when a
// point is met), the value wrapped to VALUE_WIDTH bits and sign-extended, and the count
// of bytes consumed, saturating at COUNT_WIDTH bits. Value and count are zero unless the
// status is integer. Bytes after a result are ignored until the next first byte.
// Throughput is one byte per cycle while the input is not stalled, set by the single
// scan step that updates the phase, accumulator and count registers for each byte it
// consumes. A byte is first captured in the input register; its result is loaded into
// the result register when the step consumes the byte. The input is stalled only while
// a byte that ends a literal waits for a full result register that is not being taken.
`include "assert_macros.svh"

module integer_literal_scanner_core #(
  parameter int VALUE_WIDTH = ils_pkg::VALUE_WIDTH_DEF,
  parameter int COUNT_WIDTH = ils_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [7:0]                            in_character,
  input  logic                                  in_first_char,
  input  logic                                  in_last_char,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [1:0]                            out_status,
  output logic signed [ils_pkg::OUT_VALUE_W-1:0] out_value,
  output logic [ils_pkg::OUT_COUNT_W-1:0]       out_consumed
);
  import ils_pkg::*;

  // Input register stage.
  logic                   s1_valid_r;
  logic [7:0]             s1_char_r;
  logic                   s1_first_r;
  logic                   s1_last_r;

  // Scan state.
  ils_ctl_t               ctl_r;
  logic [VALUE_WIDTH-1:0] acc_r;
  logic [COUNT_WIDTH-1:0] cnt_r;

  // Result register.
  logic                   out_valid_r;
  status_t                out_status_r;
  logic [OUT_VALUE_W-1:0] out_value_r;
  logic [OUT_COUNT_W-1:0] out_consumed_r;

  // Step outputs.
  ils_ctl_t               ctl_nxt;
  logic [VALUE_WIDTH-1:0] acc_nxt;
  logic [COUNT_WIDTH-1:0] cnt_nxt;
  ils_res_t               step_res;
  logic [OUT_VALUE_W-1:0] step_value;
  logic [OUT_COUNT_W-1:0] step_consumed;

  logic                   out_free;
  logic                   s1_fire;
  logic                   out_payload_zero;

  ils_step #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .ch           (s1_char_r),
    .first        (s1_first_r),
    .last         (s1_last_r),
    .cur_ctl      (ctl_r),
    .cur_acc      (acc_r),
    .cur_cnt      (cnt_r),
    .nxt_ctl      (ctl_nxt),
    .nxt_acc      (acc_nxt),
    .nxt_cnt      (cnt_nxt),
    .res          (step_res),
    .res_value    (step_value),
    .res_consumed (step_consumed)
  );

  // The result register can take a new beat if it is empty or being drained this cycle.
  // A byte that makes no result never waits for it.
  assign out_free = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && (!step_res.emit || out_free);
  assign in_ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_char_r  <= in_character;
      s1_first_r <= in_first_char;
      s1_last_r  <= in_last_char;
    end
  end

  // Scan state advances only when the buffered byte is consumed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.phase <= PH_IDLE;
      ctl_r.neg   <= 1'b0;
      acc_r       <= '0;
      cnt_r       <= '0;
    end else if (s1_fire) begin
      ctl_r <= ctl_nxt;
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && step_res.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && step_res.emit) begin
      out_status_r   <= step_res.status;
      out_value_r    <= step_value;
      out_consumed_r <= step_consumed;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_value    = out_value_r;
  assign out_consumed = out_consumed_r;

  assign out_payload_zero = (out_value_r == '0) && (out_consumed_r == '0);

  // A byte that ends a literal always lands in the result register.
  `ASSERT_NEXT(a_emit_lands, s1_fire && step_res.emit, out_valid_r, "result beat lost")
  // Every result returns the scanner to idle.
  `ASSERT_NEXT(a_emit_idle, s1_fire && step_res.emit, ctl_r.phase == PH_IDLE, "scan not idle")
  // Only integer results carry a value or a count.
  `ASSERT_ALWAYS(a_nonint_zero, !out_valid_r || out_status_r == ST_INT || out_payload_zero, "bad payload")
  // The input stalls only behind a stalled result register.
  `ASSERT_ALWAYS(a_stall_cause, in_ready || (s1_valid_r && out_valid_r && !out_ready), "bad stall")

endmodule

@@ sim/literal_checker.sv @@
`timescale 1ns / 1ps
// Checker for the integer literal scanner: predicts each result beat and compares it.
module literal_checker (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  input  logic                                   in_ready,
  input  logic [7:0]                             in_character,
  input  logic                                   in_first_char,
  input  logic                                   in_last_char,
  input  logic                                   out_valid,
  input  logic                                   out_ready,
  input  logic [1:0]                             out_status,
  input  logic signed [ils_pkg::OUT_VALUE_W-1:0] out_value,
  input  logic [ils_pkg::OUT_COUNT_W-1:0]        out_consumed,
  output int                                     fail_count,
  output int                                     pending,
  output int                                     checked
);
  import ils_pkg::*;

  typedef struct {
    status_t                        status;
    logic signed [OUT_VALUE_W-1:0]  value;
    logic [OUT_COUNT_W-1:0]         consumed;
  } literal_result_t;

  literal_result_t literal_q[$];

  phase_t                     scan_phase;
  logic [VALUE_WIDTH_DEF-1:0] accum;
  logic                       negative;
  logic [COUNT_WIDTH_DEF-1:0] char_count;

  function automatic bit is_dec(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit is_hex(input logic [7:0] c);
    return is_dec(c) || (c >= CH_UP_A && c <= CH_UP_F) || (c >= CH_LO_A && c <= CH_LO_F);
  endfunction

  function automatic logic [3:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    if (is_dec(c)) v = c - CH_ZERO;
    else if (c >= CH_UP_A && c <= CH_UP_F) v = c - CH_UP_A + 8'd10;
    else v = c - CH_LO_A + 8'd10;
    return v[3:0];
  endfunction

  function automatic void bump_count();
    if (char_count != '1) char_count = char_count + 1'b1;
  endfunction

  function automatic void take_decimal(input logic [7:0] c);
    accum = accum * 10 + digit_value(c);
    bump_count();
  endfunction

  // Queues the result that ends the current scan and returns the scanner to idle.
  function automatic void finish_scan(input status_t st);
    literal_result_t r;
    r.status   = st;
    r.value    = '0;
    r.consumed = '0;
    if (st == ST_INT) begin
      r.value    = negative ? -accum : accum;
      r.consumed = char_count;
    end
    literal_q.push_back(r);
    scan_phase = PH_IDLE;
  endfunction

  // One byte of the scan: updates the scan state and queues any result it causes.
  function automatic void advance_scan(input logic [7:0] c, input logic first,
                                       input logic last);
    phase_t ph;
    ph = scan_phase;
    if (first) begin
      accum      = '0;
      negative   = 1'b0;
      char_count = '0;
      ph         = PH_START;
    end
    case (ph)
      PH_START: begin
        if (c == CH_ZERO) begin
          bump_count();
          scan_phase = PH_ZERO;
          if (last) finish_scan(ST_INT);
        end else if (c == CH_MINUS) begin
          negative = 1'b1;
          bump_count();
          scan_phase = PH_MINUS;
          if (last) finish_scan(ST_NAN);
        end else if (c == CH_POINT) begin
          finish_scan(ST_FLOAT);
        end else if (!is_dec(c)) begin
          finish_scan(ST_NAN);
        end else begin
          take_decimal(c);
          scan_phase = PH_DEC;
          if (last) finish_scan(ST_INT);
        end
      end
      PH_MINUS: begin
        if (c == CH_POINT) finish_scan(ST_FLOAT);
        else if (!is_dec(c)) finish_scan(ST_NAN);
        else begin
          scan_phase = (c == CH_ZERO) ? PH_MINUS_ZERO : PH_DEC;
          take_decimal(c);
          if (last) finish_scan(ST_INT);
        end
      end
      PH_ZERO, PH_MINUS_ZERO: begin
        if (c == CH_LO_X) begin
          bump_count();
          scan_phase = PH_HEX_START;
          if (last) finish_scan(ST_NAN);
        end else if (c == CH_POINT) begin
          finish_scan(ST_FLOAT);
        end else if (!is_dec(c)) begin
          finish_scan(ST_INT);
        end else begin
          take_decimal(c);
          scan_phase = PH_DEC;
          if (last) finish_scan(ST_INT);
        end
      end
      PH_HEX_START, PH_HEX: begin
        if (ph == PH_HEX && c == CH_POINT) begin
          finish_scan(ST_FLOAT);
        end else if (!is_hex(c)) begin
          finish_scan(ph == PH_HEX ? ST_INT : ST_NAN);
        end else begin
          accum = {accum[VALUE_WIDTH_DEF-5:0], digit_value(c)};
          bump_count();
          scan_phase = PH_HEX;
          if (last) finish_scan(ST_INT);
        end
      end
      PH_DEC: begin
        if (c == CH_POINT) finish_scan(ST_FLOAT);
        else if (!is_dec(c)) finish_scan(ST_INT);
        else begin
          take_decimal(c);
          if (last) finish_scan(ST_INT);
        end
      end
      default: scan_phase = PH_IDLE;
    endcase
  endfunction

  always @(posedge clk) begin
    literal_result_t want;
    if (!rst_n) begin
      scan_phase = PH_IDLE;
      accum      = '0;
      negative   = 1'b0;
      char_count = '0;
      literal_q.delete();
      fail_count = 0;
      checked    = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (literal_q.size() == 0) begin
          fail_count++;
          $display("%0t ns: unexpected result beat: status %0d value %0d consumed %0d",
                   $time, out_status, out_value, out_consumed);
        end else begin
          want = literal_q.pop_front();
          checked++;
          if (out_status !== want.status || out_value !== want.value ||
              out_consumed !== want.consumed) begin
            fail_count++;
            $display("%0t ns: mismatch: expected status %0d value %0d consumed %0d, got %0d %0d %0d",
                     $time, want.status, want.value, want.consumed,
                     out_status, out_value, out_consumed);
          end
        end
      end
      if (in_valid && in_ready) advance_scan(in_character, in_first_char, in_last_char);
    end
    pending = literal_q.size();
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// Testbench top for the integer literal scanner: byte stream stimulus and verdict.
module testbench;
  import ils_pkg::*;

  typedef logic [7:0] text_t[$];

  // The bound leaves a wide margin for a correct run, even when every byte waits
  // behind a slow receiver and a long hold-off.
  localparam int CYCLE_LIMIT  = 100_000;
  localparam int RANDOM_BYTES = 380;
  localparam int HOLD_CYCLES  = 300;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [7:0]                    in_character;
  logic                          in_first_char;
  logic                          in_last_char;
  logic                          out_valid;
  logic                          out_ready;
  logic [1:0]                    out_status;
  logic signed [OUT_VALUE_W-1:0] out_value;
  logic [OUT_COUNT_W-1:0]        out_consumed;

  int fail_count;
  int pending;
  int checked;

  int bytes_sent;
  int literal_bytes;
  int burst_left;
  bit hold_req;

  integer_literal_scanner_core DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_character (in_character),
    .in_first_char(in_first_char),
    .in_last_char (in_last_char),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_value    (out_value),
    .out_consumed (out_consumed)
  );

  literal_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_character (in_character),
    .in_first_char(in_first_char),
    .in_last_char (in_last_char),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_value    (out_value),
    .out_consumed (out_consumed),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked      (checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a run that has not finished by now is hung.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles with %0d results outstanding", CYCLE_LIMIT, pending);
    $display("TEST FAILED");
    $finish;
  end

  // Receiver. The stall pattern is redrawn periodically from always ready, ready on a coin
  // toss and ready one cycle in four. When the stimulus asks for it, the receiver holds
  // off for a long stretch so results pile up and the input stalls.
  initial begin
    int cyc;
    int mode;
    bit hold_done;
    cyc       = 0;
    mode      = 0;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      if (cyc % 50 == 0) mode = $urandom_range(0, 2);
      cyc++;
      case (mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Offers one beat and returns at the falling edge after it is accepted, with valid
  // still high. Beats come in bursts; between bursts valid drops for a random gap.
  task automatic send_byte(input logic [7:0] c, input logic first, input logic last);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    in_valid      <= 1'b1;
    in_character  <= c;
    in_first_char <= first;
    in_last_char  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    bytes_sent++;
  endtask

  // Sends a literal: the first byte starts the scan, the last one may close the buffer.
  task automatic send_text(input text_t text, input bit end_last);
    foreach (text[i]) send_byte(text[i], i == 0, end_last && i == text.size() - 1);
    literal_bytes += text.size();
  endtask

  task automatic send_string(input string s, input bit end_last);
    text_t text;
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    send_text(text, end_last);
  endtask

  function automatic logic [7:0] hex_char(input int v, input bit upper);
    if (v < 10) return CH_ZERO + 8'(v);
    return (upper ? CH_UP_A : CH_LO_A) + 8'(v - 10);
  endfunction

  // A well-formed literal with random content, ended by a random byte, a point, the
  // end of the buffer, or simply the start of the next literal.
  task automatic random_literal();
    text_t text;
    int ending;
    if ($urandom_range(0, 2) == 0) text.push_back(CH_MINUS);
    if ($urandom_range(0, 1) == 1) begin
      text.push_back(CH_ZERO);
      text.push_back(CH_LO_X);
      repeat ($urandom_range(1, 10)) text.push_back(hex_char($urandom_range(0, 15),
                                                             1'($urandom_range(0, 1))));
    end else begin
      repeat ($urandom_range(1, 12)) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    end
    ending = $urandom_range(0, 3);
    case (ending)
      0:       text.push_back(8'($urandom_range(0, 255)));
      1:       text.push_back(CH_POINT);
      default: ;
    endcase
    send_text(text, ending == 2);
    // Bytes after a result should be dropped by the scanner.
    if (ending < 2 && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
  endtask

  // Malformed or cut-short literals: lone signs, bare prefixes, leading points and
  // random garbage as the first byte.
  task automatic broken_literal();
    text_t text;
    bit end_last;
    end_last = 1'b0;
    case ($urandom_range(0, 4))
      0: begin
        text.push_back(CH_MINUS);
        text.push_back(8'($urandom_range(0, 255)));
      end
      1: begin
        if ($urandom_range(0, 1) == 1) text.push_back(CH_MINUS);
        text.push_back(CH_ZERO);
        text.push_back(CH_LO_X);
        if ($urandom_range(0, 1) == 1) end_last = 1'b1;
        else text.push_back(8'($urandom_range(0, 255)));
      end
      2: begin
        text.push_back(CH_MINUS);
        end_last = 1'b1;
      end
      3: begin
        if ($urandom_range(0, 1) == 1) text.push_back(CH_MINUS);
        text.push_back(CH_POINT);
      end
      default: begin
        repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(0, 255)));
      end
    endcase
    send_text(text, end_last);
  endtask

  initial begin
    bytes_sent    = 0;
    literal_bytes = 0;
    burst_left    = 0;
    hold_req      = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_character  = 8'h00;
    in_first_char = 1'b0;
    in_last_char  = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: a leading point, a lone sign at the end of the buffer, sign then
    // point, a bare prefix, minus zero closed by a NUL byte, points after hex and
    // decimal digits, a short negative closed by the end of the buffer, a restart in
    // the middle of a scan, an idle byte with every bit set, and a lone zero.
    send_string(".", 1'b0);
    send_string("-", 1'b1);
    send_string("-.", 1'b0);
    send_string("0xg", 1'b0);
    send_string("-0", 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_string("0xF.", 1'b0);
    send_string("7.", 1'b0);
    send_string("-9", 1'b1);
    send_string("12", 1'b0);
    send_string("a", 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_string("0", 1'b1);

    // Random part: mostly well-formed literals, some broken ones and some noise. The
    // long receiver hold-off is requested as it starts.
    hold_req = 1'b1;
    while (literal_bytes < RANDOM_BYTES) begin
      if ($urandom_range(0, 9) < 7) random_literal();
      else broken_literal();
      if ($urandom_range(0, 15) == 0)
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    end
    in_valid <= 1'b0;

    // Drain: every expected result must come out, then a few cycles to catch strays.
    while (pending != 0) @(negedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes, %0d of them in literals: decimal and hex, wrapping values,",
             bytes_sent, literal_bytes);
    $display("restarts and malformed text; checked %0d results under a %0d-cycle hold-off.",
             checked, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/ils_pkg.sv
rtl/ils_step.sv
rtl/integer_literal_scanner_core.sv
sim/literal_checker.sv
sim/testbench.sv
